FILE: src/assert_macros.svh
// Assertion macros shared by the collision block RTL.
// No dependencies; taken in by `include where assertions are written.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, reset masks the check.
`define SPCM_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, reset masks the check.
`define SPCM_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: src/spcm_pkg.sv
// Types, constants and pixel helpers for the sprite collision block.
// No dependencies; used by every module of the block.
package spcm_pkg;

    localparam int ROW_BITS  = 24;   // pixels in one unscaled row
    localparam int LINE_W    = 48;   // pixels in one doubled row
    localparam int SPR_W     = 24;
    localparam int ROW_IDX_W = 5;    // row number, up to 21 rows
    localparam int IDX_W     = 3;    // sprite number
    localparam int LAST_BYTE = 63;   // byte index that is never stored

    typedef enum logic [1:0] {
        REQ_ATTR    = 2'd0,
        REQ_BITMAP  = 2'd1,
        REQ_COMPUTE = 2'd2,
        REQ_NONE    = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAIR,
        ST_READ,
        ST_CHECK,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic       dh;
        logic       dw;
        logic       mc;
        logic       en;
        logic [7:0] y;
        logic [8:0] x;
    } t_attr;

    // Opaque flags with pixel n at bit n (leftmost pixel in bit 0).
    function automatic logic [ROW_BITS-1:0] opacity(input logic [ROW_BITS-1:0] row,
                                                    input logic mc);
        logic [ROW_BITS-1:0] p;
        for (int x = 0; x < ROW_BITS; x++) begin
            if (mc) begin
                p[x] = row[ROW_BITS-1-2*(x/2)] | row[ROW_BITS-2-2*(x/2)];
            end else begin
                p[x] = row[ROW_BITS-1-x];
            end
        end
        return p;
    endfunction

    // Horizontal doubling onto a 48-pixel line.
    function automatic logic [LINE_W-1:0] widen(input logic [ROW_BITS-1:0] p,
                                                input logic dw);
        logic [LINE_W-1:0] w;
        for (int k = 0; k < LINE_W; k++) begin
            if (dw) begin
                w[k] = p[k/2];
            end else if (k < ROW_BITS) begin
                w[k] = p[k];
            end else begin
                w[k] = 1'b0;
            end
        end
        return w;
    endfunction

endpackage

FILE: src/spcm_row_mem.sv
// Bitmap row memory: one 24-bit row per word, byte-lane writes, two read ports.
// Depends on spcm_pkg.
module spcm_row_mem #(
    parameter int DEPTH = 168,
    parameter int AW    = 8
) (
    input  logic                         i_clk,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [1:0]                   i_wlane,
    input  logic [7:0]                   i_wdata,
    input  logic [AW-1:0]                i_raddr_a,
    input  logic [AW-1:0]                i_raddr_b,
    output logic [spcm_pkg::ROW_BITS-1:0] o_rdata_a,
    output logic [spcm_pkg::ROW_BITS-1:0] o_rdata_b
);

    logic [spcm_pkg::ROW_BITS-1:0] mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr][i_wlane*8 +: 8] <= i_wdata;
        end
        o_rdata_a <= mem[i_raddr_a];
        o_rdata_b <= mem[i_raddr_b];
    end

endmodule

FILE: src/spcm_line_check.sv
// One screen line of a sprite pair: expands both rows and tests for overlap.
// Depends on spcm_pkg.
module spcm_line_check (
    input  logic [spcm_pkg::ROW_BITS-1:0] i_row_f,
    input  logic [spcm_pkg::ROW_BITS-1:0] i_row_g,
    input  spcm_pkg::t_attr               i_attr_f,
    input  spcm_pkg::t_attr               i_attr_g,
    output logic                          o_hit
);

    logic [spcm_pkg::LINE_W-1:0] w_f;
    logic [spcm_pkg::LINE_W-1:0] w_g;
    logic [8:0]                  d;

    always_comb begin
        w_f = spcm_pkg::widen(spcm_pkg::opacity(i_row_f, i_attr_f.mc), i_attr_f.dw);
        w_g = spcm_pkg::widen(spcm_pkg::opacity(i_row_g, i_attr_g.mc), i_attr_g.dw);
        if (i_attr_g.x >= i_attr_f.x) begin
            d     = i_attr_g.x - i_attr_f.x;
            o_hit = |((w_f >> d) & w_g);
        end else begin
            d     = i_attr_f.x - i_attr_g.x;
            o_hit = |((w_g >> d) & w_f);
        end
    end

endmodule

FILE: src/sprite_pair_collision_mask_unit.sv
// Sprite pair collision mask: top level with sequencer and attribute registers.
// Depends on spcm_pkg, spcm_row_mem, spcm_line_check, assert_macros.svh.
// A compute item walks the sprite pairs and, for each overlapping pair, the
// overlapping screen lines; the line loop does one row read per sprite of the pair
// on the two memory ports, then a compare. Result sits in an output
// register. Reset clears attributes (all sprites off); bitmap rows are not cleared.
`include "assert_macros.svh"

module sprite_pair_collision_mask_unit #(
    parameter int NUM_SPRITES   = 8,
    parameter int SPRITE_HEIGHT = 21
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    // [2:0] sprite_index, [8:3] byte_index, [16:9] byte_value, [25:17] pos_x,
    // [33:26] pos_y, [34] enable, [35] multicolor, [36] double_width,
    // [37] double_height, [39:38] zero
    input  logic [39:0] i_s_axis_tdata,
    // [1:0] req_type
    input  logic [1:0]  i_s_axis_tuser,
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    // [7:0] collision_mask
    output logic [7:0]  o_m_axis_tdata
);

    localparam int DEPTH = NUM_SPRITES * SPRITE_HEIGHT;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int IW    = spcm_pkg::IDX_W;
    localparam int RW    = spcm_pkg::ROW_IDX_W;

    // input item fields
    logic [2:0] in_si;
    logic [5:0] in_bi;
    logic [7:0] in_bv;
    spcm_pkg::t_attr in_attr;
    spcm_pkg::t_req  in_req;
    logic            acc;

    assign in_si   = i_s_axis_tdata[2:0];
    assign in_bi   = i_s_axis_tdata[8:3];
    assign in_bv   = i_s_axis_tdata[16:9];
    assign in_attr = '{dh: i_s_axis_tdata[37], dw: i_s_axis_tdata[36],
                       mc: i_s_axis_tdata[35], en: i_s_axis_tdata[34],
                       y: i_s_axis_tdata[33:26], x: i_s_axis_tdata[25:17]};
    assign in_req  = spcm_pkg::t_req'(i_s_axis_tuser);

    // sequencer state
    spcm_pkg::t_state r_state, n_state;
    logic [IW-1:0]    r_f, n_f, r_g, n_g;
    logic [8:0]       r_y, n_y, r_yend, n_yend;
    logic [7:0]       r_mask, n_mask;
    logic             r_out_valid, n_out_valid;
    logic [7:0]       r_out_data, n_out_data;
    spcm_pkg::t_attr  r_attr [NUM_SPRITES];

    assign o_s_axis_tready = (r_state == spcm_pkg::ST_IDLE);
    assign acc             = i_s_axis_tvalid && o_s_axis_tready;
    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

    // bitmap write decode: row = byte / 3 via reciprocal, column byte = remainder
    logic [12:0]   wr_prod;
    logic [RW-1:0] wr_row;
    logic [1:0]    wr_col;
    logic          wr_en;
    logic [AW-1:0] wr_addr;

    always_comb begin
        wr_prod = 13'(in_bi) * 13'd43;
        wr_row  = RW'(wr_prod >> 7);
        wr_col  = 2'(in_bi - 6'(wr_row) * 6'd3);
        wr_en   = acc && (in_req == spcm_pkg::REQ_BITMAP)
                  && (32'(in_si) < NUM_SPRITES)
                  && (32'(in_bi) < spcm_pkg::LAST_BYTE)
                  && (32'(wr_row) < SPRITE_HEIGHT);
        wr_addr = AW'(32'(in_si) * SPRITE_HEIGHT + 32'(wr_row));
    end

    // current pair attributes and geometry
    spcm_pkg::t_attr a_f, a_g;
    logic [9:0]      f_r, g_r;           // right edge, exclusive
    logic [8:0]      f_b, g_b;           // bottom edge, exclusive
    logic            pair_ovl;
    logic [8:0]      y_lo, y_hi;
    logic [5:0]      dy_f, dy_g;
    logic [AW-1:0]   rd_a, rd_b;
    logic            last_pair;

    always_comb begin
        a_f      = r_attr[r_f];
        a_g      = r_attr[r_g];
        f_r      = 10'(a_f.x) + (a_f.dw ? 10'd48 : 10'd24);
        g_r      = 10'(a_g.x) + (a_g.dw ? 10'd48 : 10'd24);
        f_b      = 9'(a_f.y) + (a_f.dh ? 9'(2 * SPRITE_HEIGHT) : 9'(SPRITE_HEIGHT));
        g_b      = 9'(a_g.y) + (a_g.dh ? 9'(2 * SPRITE_HEIGHT) : 9'(SPRITE_HEIGHT));
        pair_ovl = a_f.en && a_g.en && (f_r > 10'(a_g.x)) && (g_r > 10'(a_f.x))
                   && (f_b > 9'(a_g.y)) && (g_b > 9'(a_f.y));
        y_lo     = (a_f.y > a_g.y) ? 9'(a_f.y) : 9'(a_g.y);
        y_hi     = (f_b < g_b) ? f_b : g_b;
        dy_f     = 6'(r_y - 9'(a_f.y));
        dy_g     = 6'(r_y - 9'(a_g.y));
        rd_a     = AW'(32'(r_f) * SPRITE_HEIGHT + 32'(a_f.dh ? (dy_f >> 1) : dy_f));
        rd_b     = AW'(32'(r_g) * SPRITE_HEIGHT + 32'(a_g.dh ? (dy_g >> 1) : dy_g));
        last_pair = (32'(r_f) == NUM_SPRITES - 2) && (32'(r_g) == NUM_SPRITES - 1);
    end

    logic [spcm_pkg::ROW_BITS-1:0] row_f, row_g;
    logic                          hit;

    spcm_row_mem #(.DEPTH(DEPTH), .AW(AW)) u_mem (
        .i_clk     (i_clk),
        .i_we      (wr_en),
        .i_waddr   (wr_addr),
        .i_wlane   (2'd2 - wr_col),
        .i_wdata   (in_bv),
        .i_raddr_a (rd_a),
        .i_raddr_b (rd_b),
        .o_rdata_a (row_f),
        .o_rdata_b (row_g)
    );

    spcm_line_check u_line (
        .i_row_f  (row_f),
        .i_row_g  (row_g),
        .i_attr_f (a_f),
        .i_attr_g (a_g),
        .o_hit    (hit)
    );

    // next state and datapath
    always_comb begin
        logic adv;
        adv         = 1'b0;
        n_state     = r_state;
        n_f         = r_f;
        n_g         = r_g;
        n_y         = r_y;
        n_yend      = r_yend;
        n_mask      = r_mask;
        n_out_valid = r_out_valid && !i_m_axis_tready;
        n_out_data  = r_out_data;
        case (r_state)
            spcm_pkg::ST_IDLE: begin
                if (acc && in_req == spcm_pkg::REQ_COMPUTE) begin
                    n_f     = '0;
                    n_g     = IW'(1);
                    n_mask  = '0;
                    n_state = spcm_pkg::ST_PAIR;
                end
            end
            spcm_pkg::ST_PAIR: begin
                if (pair_ovl) begin
                    n_y     = y_lo;
                    n_yend  = y_hi;
                    n_state = spcm_pkg::ST_READ;
                end else begin
                    adv = 1'b1;
                end
            end
            spcm_pkg::ST_READ: begin
                n_state = spcm_pkg::ST_CHECK;
            end
            spcm_pkg::ST_CHECK: begin
                if (hit) begin
                    n_mask = r_mask | (8'd1 << r_f) | (8'd1 << r_g);
                    adv    = 1'b1;
                end else if (r_y + 9'd1 == r_yend) begin
                    adv = 1'b1;
                end else begin
                    n_y     = r_y + 9'd1;
                    n_state = spcm_pkg::ST_READ;
                end
            end
            spcm_pkg::ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_mask;
                    n_state     = spcm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = spcm_pkg::ST_IDLE;
            end
        endcase
        if (adv) begin
            if (last_pair) begin
                n_state = spcm_pkg::ST_DONE;
            end else if (32'(r_g) == NUM_SPRITES - 1) begin
                n_f     = r_f + IW'(1);
                n_g     = r_f + IW'(2);
                n_state = spcm_pkg::ST_PAIR;
            end else begin
                n_g     = r_g + IW'(1);
                n_state = spcm_pkg::ST_PAIR;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= spcm_pkg::ST_IDLE;
            r_out_valid <= 1'b0;
            r_f         <= '0;
            r_g         <= IW'(1);
            for (int i = 0; i < NUM_SPRITES; i++) begin
                r_attr[i] <= '0;
            end
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_f         <= n_f;
            r_g         <= n_g;
            if (acc && in_req == spcm_pkg::REQ_ATTR && 32'(in_si) < NUM_SPRITES) begin
                r_attr[in_si] <= in_attr;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_y        <= n_y;
        r_yend     <= n_yend;
        r_mask     <= n_mask;
        r_out_data <= n_out_data;
    end

    `SPCM_ASSERT_NEXT(a_read_then_check, i_clk, i_rst_n, r_state == spcm_pkg::ST_READ,
        r_state == spcm_pkg::ST_CHECK, "row read not followed by line check")
    `SPCM_ASSERT_NOW(a_line_in_range, i_clk, i_rst_n,
        r_state == spcm_pkg::ST_READ || r_state == spcm_pkg::ST_CHECK,
        r_y < r_yend, "line counter past overlap")
    `SPCM_ASSERT_NOW(a_pair_order, i_clk, i_rst_n,
        r_state == spcm_pkg::ST_PAIR || r_state == spcm_pkg::ST_CHECK,
        r_g > r_f, "pair counters out of order")
    `SPCM_ASSERT_NEXT(a_done_loads, i_clk, i_rst_n,
        r_state == spcm_pkg::ST_DONE && !r_out_valid,
        r_out_valid && r_state == spcm_pkg::ST_IDLE, "result not loaded")

endmodule

FILE: dv/sprite_pair_collision_mask_unit_test.sv
// Self-checking bench for the sprite pair collision mask unit.
// Depends on spcm_pkg and the unit's RTL; predicts every mask in place.
`timescale 1ns / 100ps

module sprite_pair_collision_mask_unit_test;

    localparam int SPRITES      = 8;
    localparam int ROWS         = 21;
    localparam int BYTES        = 63;
    localparam int RANDOM_ITEMS = 1100;
    localparam int QUIET_TAIL   = 150;    // last items go through without idling
    localparam int LONG_HOLD    = 3000;   // receiver back-pressure stretch
    localparam int WATCHDOG     = 20000;  // idle cycles before giving up
    localparam int SETTLE       = 50;

    typedef struct {
        spcm_pkg::t_req req;
        logic [2:0] spr;
        logic [5:0] bidx;
        logic [7:0] bval;
        logic [8:0] x;
        logic [7:0] y;
        logic       en, mc, dw, dh;
        logic       drain;  // wait for every mask before sending
    } t_item;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_valid;
    logic        s_ready;
    logic [39:0] s_data;   // spr, bidx, bval, x, y, en, mc, dw, dh, zero pad
    logic [1:0]  s_user;   // req_type
    logic        m_valid;
    logic        m_ready;
    logic [7:0]  m_data;   // collision_mask

    sprite_pair_collision_mask_unit uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (s_valid),
        .o_s_axis_tready (s_ready),
        .i_s_axis_tdata  (s_data),
        .i_s_axis_tuser  (s_user),
        .o_m_axis_tvalid (m_valid),
        .i_m_axis_tready (m_ready),
        .o_m_axis_tdata  (m_data)
    );

    t_item      pending[$];
    logic [7:0] masks_due[$];
    t_item      in_flight;

    // predictor state
    spcm_pkg::t_attr spr_attr [SPRITES];
    logic [7:0]      spr_bits [SPRITES][BYTES];

    // generator shadow: which bytes are loaded, which sprites may be read
    bit gen_loaded [SPRITES][BYTES];

    int  mismatches = 0;
    int  masks_seen = 0;
    int  idle_count = 0;
    int  send_gap = 0;
    int  recv_hold = 0;
    bit  long_hold_done = 0;
    logic quiet;

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // ---------------- predictor ----------------
    function automatic bit pixel_on(int s, int lx, int ly);
        int bx, by, c;
        logic [7:0] d;
        bx = spr_attr[s].dw ? lx / 2 : lx;
        by = spr_attr[s].dh ? ly / 2 : ly;
        if (spr_attr[s].mc) begin
            c = bx / 2;
            d = spr_bits[s][by * 3 + c / 4];
            return ((d >> (6 - (c % 4) * 2)) & 8'h03) != 0;
        end
        d = spr_bits[s][by * 3 + bx / 8];
        return d[7 - bx % 8];
    endfunction

    function automatic bit pair_hits(int f, int g);
        int fl, ft, fr, fb, gl, gt, gr, gb, x0, x1, y0, y1;
        fl = spr_attr[f].x;  ft = spr_attr[f].y;
        gl = spr_attr[g].x;  gt = spr_attr[g].y;
        fr = fl + (spr_attr[f].dw ? 48 : 24);
        fb = ft + (spr_attr[f].dh ? 2 * ROWS : ROWS);
        gr = gl + (spr_attr[g].dw ? 48 : 24);
        gb = gt + (spr_attr[g].dh ? 2 * ROWS : ROWS);
        x0 = (fl > gl) ? fl : gl;  x1 = (fr < gr) ? fr : gr;
        y0 = (ft > gt) ? ft : gt;  y1 = (fb < gb) ? fb : gb;
        if (x0 >= x1 || y0 >= y1) return 0;
        for (int yy = y0; yy < y1; yy++)
            for (int xx = x0; xx < x1; xx++)
                if (pixel_on(f, xx - fl, yy - ft) && pixel_on(g, xx - gl, yy - gt))
                    return 1;
        return 0;
    endfunction

    function automatic logic [7:0] collision_mask();
        logic [7:0] m;
        m = '0;
        for (int f = 0; f < SPRITES; f++)
            for (int g = f + 1; g < SPRITES; g++)
                if (spr_attr[f].en && spr_attr[g].en && pair_hits(f, g)) begin
                    m[f] = 1'b1;
                    m[g] = 1'b1;
                end
        return m;
    endfunction

    task automatic apply_item(t_item it);
        case (it.req)
            spcm_pkg::REQ_ATTR: begin
                spr_attr[it.spr] = '{dh: it.dh, dw: it.dw, mc: it.mc, en: it.en,
                                     y: it.y, x: it.x};
            end
            spcm_pkg::REQ_BITMAP: begin
                if (it.bidx < spcm_pkg::LAST_BYTE) spr_bits[it.spr][it.bidx] = it.bval;
            end
            spcm_pkg::REQ_COMPUTE: masks_due.push_back(collision_mask());
            default: ;  // unused request, dropped by the block
        endcase
    endtask

    // ---------------- stimulus building ----------------
    function automatic t_item blank_item(spcm_pkg::t_req r);
        t_item it;
        it = '{req: r, spr: 3'($urandom), bidx: 6'($urandom), bval: 8'($urandom),
               x: 9'($urandom), y: 8'($urandom), en: 1'($urandom), mc: 1'($urandom),
               dw: 1'($urandom), dh: 1'($urandom), drain: 1'b0};
        return it;
    endfunction

    task automatic add_bitmap(int s, int b, logic [7:0] v);
        t_item it;
        it = blank_item(spcm_pkg::REQ_BITMAP);
        it.spr = 3'(s);  it.bidx = 6'(b);  it.bval = v;
        pending.push_back(it);
        if (b < BYTES) gen_loaded[s][b] = 1;
    endtask

    // enabling a sprite first loads any bitmap byte never written, so no read
    // of an unwritten byte can happen
    task automatic add_attr(int s, int x, int y, bit en, bit mc, bit dw, bit dh);
        t_item it;
        logic [7:0] v;
        if (en)
            for (int b = 0; b < BYTES; b++)
                if (!gen_loaded[s][b]) begin
                    v = 8'($urandom);
                    if ($urandom_range(0, 2) == 0) v = v & 8'($urandom);
                    add_bitmap(s, b, v);
                end
        it = blank_item(spcm_pkg::REQ_ATTR);
        it.spr = 3'(s);  it.x = 9'(x);  it.y = 8'(y);
        it.en = en;  it.mc = mc;  it.dw = dw;  it.dh = dh;
        pending.push_back(it);
    endtask

    task automatic add_compute(bit drain);
        t_item it;
        it = blank_item(spcm_pkg::REQ_COMPUTE);
        it.drain = drain;
        pending.push_back(it);
    endtask

    // ---------------- driver ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            s_user  <= spcm_pkg::REQ_NONE;
            quiet   <= 1'b0;
        end else begin
            if (s_valid && s_ready) apply_item(in_flight);
            quiet <= (pending.size() < QUIET_TAIL);
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    s_valid <= 1'b0;
                end else if (pending.size() == 0) begin
                    s_valid <= 1'b0;
                end else if (pending[0].drain) begin
                    // sender pause: hold until every mask is back, then settle
                    s_valid <= 1'b0;
                    if (masks_due.size() == 0) begin
                        pending[0].drain = 1'b0;
                        send_gap = SETTLE;
                    end
                end else if (!quiet && $urandom_range(0, 11) == 0) begin
                    send_gap = $urandom_range(0, 15);
                    s_valid <= 1'b0;
                end else begin
                    in_flight = pending.pop_front();
                    s_valid <= 1'b1;
                    s_user  <= in_flight.req;
                    s_data  <= {2'b00, in_flight.dh, in_flight.dw, in_flight.mc,
                                in_flight.en, in_flight.y, in_flight.x, in_flight.bval,
                                in_flight.bidx, in_flight.spr};
                end
            end
        end
    end

    // ---------------- monitor ----------------
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                masks_seen++;
                if (masks_due.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected mask %02h, none outstanding", m_data);
                end else begin
                    logic [7:0] want;
                    want = masks_due.pop_front();
                    if (m_data !== want) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("collision_mask: expected %02h, got %02h",
                                     want, m_data);
                    end
                end
            end
            if (recv_hold > 0) begin
                recv_hold--;
                m_ready <= 1'b0;
            end else if (!long_hold_done && masks_seen >= 30) begin
                // long stall so the block fills up and holds off its input
                long_hold_done = 1;
                recv_hold = LONG_HOLD;
                m_ready <= 1'b0;
            end else if (!quiet && $urandom_range(0, 9) == 0) begin
                recv_hold = $urandom_range(0, 15);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------- watchdog ----------------
    always @(posedge i_clk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready)) idle_count <= 0;
        else idle_count <= idle_count + 1;
        if (idle_count >= WATCHDOG) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // ---------------- sequence ----------------
    initial begin
        t_item it;
        int cx, cy, s, pick;
        i_rst_n = 1'b0;
        foreach (gen_loaded[a, b]) gen_loaded[a][b] = 0;

        // directed: corners, doubling, multicolour, ignored requests
        add_compute(0);                                  // all sprites off
        add_attr(0, 0, 0, 1, 0, 0, 0);
        add_attr(7, 10, 5, 1, 0, 1, 0);                  // overlaps sprite 0
        add_bitmap(0, 0, 8'hFF);
        add_bitmap(0, 62, 8'h00);
        add_bitmap(7, 62, 8'h80);
        add_compute(0);
        add_attr(1, 511, 255, 1, 1, 1, 1);               // far corner, all stretched
        add_attr(2, 490, 240, 1, 1, 0, 0);
        add_bitmap(1, 63, 8'hFF);                        // last byte slot: ignored
        add_compute(0);
        it = blank_item(spcm_pkg::REQ_NONE);             // unused request type
        pending.push_back(it);
        add_attr(3, 4, 8, 1, 0, 0, 1);
        add_attr(4, 20, 30, 1, 1, 1, 1);
        add_attr(7, 10, 5, 0, 1, 1, 1);                  // disabled again
        add_bitmap(3, 30, 8'h55);
        add_compute(0);
        add_attr(5, 255, 128, 0, 0, 0, 0);
        add_attr(6, 256, 127, 1, 0, 1, 1);
        add_compute(1);                                  // sender waits for all masks

        // random: sprites mostly clustered so boxes overlap
        cx = $urandom_range(0, 470);
        cy = $urandom_range(0, 220);
        while (pending.size() < RANDOM_ITEMS) begin
            pick = $urandom_range(0, 99);
            s = $urandom_range(0, SPRITES - 1);
            if (pick < 50) begin
                add_bitmap(s, $urandom_range(0, 63),
                           ($urandom_range(0, 1) ? 8'($urandom) : 8'($urandom & $urandom)));
            end else if (pick < 75) begin
                if ($urandom_range(0, 4) == 0)
                    add_attr(s, $urandom_range(0, 511), $urandom_range(0, 255),
                             1'($urandom_range(0, 1)), 1'($urandom), 1'($urandom),
                             1'($urandom));
                else
                    add_attr(s, cx + $urandom_range(0, 40), cy + $urandom_range(0, 35),
                             $urandom_range(0, 3) != 0, 1'($urandom), 1'($urandom),
                             1'($urandom));
            end else if (pick < 93) begin
                add_compute(pending.size() > 600 && pending.size() < 620);
                if ($urandom_range(0, 5) == 0) begin
                    cx = $urandom_range(0, 470);
                    cy = $urandom_range(0, 220);
                end
            end else begin
                it = blank_item(spcm_pkg::REQ_NONE);
                pending.push_back(it);
            end
        end
        add_compute(0);

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        foreach (spr_attr[k]) spr_attr[k] = '0;

        wait (pending.size() == 0);
        @(posedge i_clk);
        wait (!s_valid && masks_due.size() == 0);
        repeat (SETTLE) @(posedge i_clk);
        if (mismatches == 0 && masks_due.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

FILE: sprite_pair_collision_mask_unit.f
+incdir+src
src/spcm_pkg.sv
src/spcm_row_mem.sv
src/spcm_line_check.sv
src/sprite_pair_collision_mask_unit.sv
dv/sprite_pair_collision_mask_unit_test.sv
